// ----- sv/bb3_pkg.sv -----
`timescale 1ns / 1ps

package bb3_pkg;

    // Fixed field and register widths
    localparam int PIX_W     = 24;
    localparam int ENTRY_W   = 2 * PIX_W;
    localparam int FW_W      = 11;
    localparam int FH_W      = 13;
    localparam int ROW_W     = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [FW_W-1:0] FW_RESET     = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET     = 13'd480;
    localparam logic [FH_W-1:0] HEIGHT_LIMIT = 13'd4096;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Input item kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Result queue
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = 4;
    localparam int QCNT_W      = 5;

    // Window masks: bit i selects window row or column i (0 = oldest)
    localparam logic [2:0] ROWS_DRAIN  = 3'b011;
    localparam logic [2:0] COLS_RIGHT2 = 3'b110;

    // Reciprocal scale: q = (x * M) >> RECIP_SH
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = 14;
    localparam int X_W      = 13;
    localparam int SUM_W    = 12;

    typedef struct packed {
        logic       action;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       run_last;
        logic       frame_last;
    } t_out;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PIXEL,
        KIND_DRAIN
    } t_kind;

    typedef enum logic [1:0] {
        DIV_4,
        DIV_6,
        DIV_9
    } t_div;

    // Control that travels with one item down the pipeline
    typedef struct packed {
        t_kind      kind;
        logic [1:0] n_res;
        logic [2:0] rows;
        logic [2:0] cols_a;
        logic       run_last_a;
        logic       frame_last_a;
    } t_ctl;

    function automatic t_div f_div_code(input logic [2:0] rows, input logic [2:0] cols);
        logic rows3;
        logic cols3;
        t_div code;
        rows3 = &rows;
        cols3 = &cols;
        if (rows3 && cols3) begin
            code = DIV_9;
        end else if (rows3 || cols3) begin
            code = DIV_6;
        end else begin
            code = DIV_4;
        end
        return code;
    endfunction

    // Pixel count N of the neighborhood
    function automatic logic [3:0] f_div_n(input t_div code);
        logic [3:0] n;
        case (code)
            DIV_4:   n = 4'd4;
            DIV_6:   n = 4'd6;
            DIV_9:   n = 4'd9;
            default: n = 4'd4;
        endcase
        return n;
    endfunction

    // ceil(2^16 / 2N); exact for every x = 2*sum + N that can occur
    function automatic logic [RECIP_W-1:0] f_recip(input t_div code);
        logic [RECIP_W-1:0] m;
        case (code)
            DIV_4:   m = 14'd8192;
            DIV_6:   m = 14'd5462;
            DIV_9:   m = 14'd3641;
            default: m = 14'd8192;
        endcase
        return m;
    endfunction

endpackage

// ----- sv/bb3_lane.sv -----
`timescale 1ns / 1ps

module bb3_lane (
    input  logic                  i_clk,
    input  logic [2:0][2:0][7:0]  i_px,
    input  logic [2:0]            i_rows,
    input  logic [2:0]            i_cols_a,
    input  bb3_pkg::t_div         i_div_a,
    input  bb3_pkg::t_div         i_div_b,
    output logic [7:0]            o_q_a,
    output logic [7:0]            o_q_b
);

    logic [2:0][9:0]                  col_sum;
    logic [bb3_pkg::SUM_W-1:0]        sum_a;
    logic [bb3_pkg::SUM_W-1:0]        sum_b;
    logic [bb3_pkg::X_W-1:0]          n_x_a;
    logic [bb3_pkg::X_W-1:0]          n_x_b;
    logic [bb3_pkg::X_W-1:0]          r_x_a;
    logic [bb3_pkg::X_W-1:0]          r_x_b;
    logic [bb3_pkg::RECIP_W-1:0]      r_m_a;
    logic [bb3_pkg::RECIP_W-1:0]      r_m_b;
    logic [26:0]                      prod_a;
    logic [26:0]                      prod_b;
    logic [7:0]                       r_q_a;
    logic [7:0]                       r_q_b;

    // Column sums over the selected rows, then the two neighborhood sums
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            col_sum[c] = (i_rows[0] ? 10'(i_px[0][c]) : 10'd0)
                       + (i_rows[1] ? 10'(i_px[1][c]) : 10'd0)
                       + (i_rows[2] ? 10'(i_px[2][c]) : 10'd0);
        end
        sum_a = (i_cols_a[0] ? 12'(col_sum[0]) : 12'd0)
              + (i_cols_a[1] ? 12'(col_sum[1]) : 12'd0)
              + (i_cols_a[2] ? 12'(col_sum[2]) : 12'd0);
        sum_b = 12'(col_sum[1]) + 12'(col_sum[2]);
        n_x_a = 13'({sum_a, 1'b0}) + 13'(bb3_pkg::f_div_n(i_div_a));
        n_x_b = 13'({sum_b, 1'b0}) + 13'(bb3_pkg::f_div_n(i_div_b));
    end

    always_ff @(posedge i_clk) begin
        r_x_a <= n_x_a;
        r_x_b <= n_x_b;
        r_m_a <= bb3_pkg::f_recip(i_div_a);
        r_m_b <= bb3_pkg::f_recip(i_div_b);
    end

    // Rounded mean by reciprocal multiply
    assign prod_a = 27'(r_x_a) * 27'(r_m_a);
    assign prod_b = 27'(r_x_b) * 27'(r_m_b);

    always_ff @(posedge i_clk) begin
        r_q_a <= prod_a[bb3_pkg::RECIP_SH +: 8];
        r_q_b <= prod_b[bb3_pkg::RECIP_SH +: 8];
    end

    assign o_q_a = r_q_a;
    assign o_q_b = r_q_b;

endmodule

// ----- sv/bb3_merge.sv -----
`timescale 1ns / 1ps

module bb3_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bb3_pkg::t_ctl                 i_ctl,
    input  logic [2:0][7:0]               i_q_a,
    input  logic [2:0][7:0]               i_q_b,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output bb3_pkg::t_out                 o_out_data,
    output logic [bb3_pkg::QCNT_W-1:0]    o_level
);

    bb3_pkg::t_out                   r_queue [bb3_pkg::QUEUE_DEPTH];
    logic [bb3_pkg::QPTR_W-1:0]      r_wr;
    logic [bb3_pkg::QPTR_W-1:0]      r_rd;
    logic [bb3_pkg::QCNT_W-1:0]      r_level;
    logic [bb3_pkg::QPTR_W-1:0]      n_wr;
    logic [bb3_pkg::QPTR_W-1:0]      n_rd;
    logic [bb3_pkg::QCNT_W-1:0]      n_level;
    logic [bb3_pkg::QPTR_W-1:0]      wr_b;
    logic                            pop;
    bb3_pkg::t_out                   beat_a;
    bb3_pkg::t_out                   beat_b;

    // Lane 2 is red, lane 1 green, lane 0 blue
    always_comb begin
        beat_a.out_red    = i_q_a[2];
        beat_a.out_green  = i_q_a[1];
        beat_a.out_blue   = i_q_a[0];
        beat_a.run_last   = i_ctl.run_last_a;
        beat_a.frame_last = i_ctl.frame_last_a;
        beat_b.out_red    = i_q_b[2];
        beat_b.out_green  = i_q_b[1];
        beat_b.out_blue   = i_q_b[0];
        beat_b.run_last   = 1'b1;
        beat_b.frame_last = 1'b0;
    end

    assign pop     = o_out_valid && !i_out_stall;
    assign wr_b    = r_wr + bb3_pkg::QPTR_W'(1);
    assign n_wr    = r_wr + bb3_pkg::QPTR_W'(i_ctl.n_res);
    assign n_rd    = r_rd + bb3_pkg::QPTR_W'(pop);
    assign n_level = r_level + bb3_pkg::QCNT_W'(i_ctl.n_res) - bb3_pkg::QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.n_res != 2'd0) begin
            r_queue[r_wr] <= beat_a;
        end
        if (i_ctl.n_res == 2'd2) begin
            r_queue[wr_b] <= beat_b;
        end
    end

    assign o_out_valid = (r_level != '0);
    assign o_out_data  = r_queue[r_rd];
    assign o_level     = r_level;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= bb3_pkg::QCNT_W'(bb3_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_frame_last_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_last) |-> o_out_data.run_last)
        else $error("frame_last beat without run_last");

endmodule

// ----- sv/box_blur_3x3_edge_normalized_core.sv -----
`timescale 1ns / 1ps

// 3x3 box blur on an RGB888 raster stream, with the mean clipped at the frame edges
// (4 pixels at corners, 6 on edges, 9 inside), rounded half up per channel. Feed the
// pixels of a frame in raster order with action 0; the result for row r-1, column c-1
// comes out behind pixel (r,c), and the pixel that ends a row gives two beats, the second
// carrying the last column. After the frame, send frame_width drain ticks (action 1) to
// get the last row, one beat per tick; frame_last marks its final beat. A pixel sent
// while drain beats are still pending drops them and opens a new frame. Program
// frame_width (2..MAX_WIDTH) and frame_height (2..4096) only while the block is idle.
// Rate: one input beat per clock while o_in_stall is low. A result reaches the output
// queue through stages 1 (windows), 2-3 (lanes) and 4 (merge). The output side moves
// one beat per clock while i_out_stall is low, so row-end pixels, which make two beats,
// slow a sustained stream; a 16-entry result queue with credit counting sets when input
// stalls. The line store is one memory of MAX_WIDTH entries holding two rows side by
// side, with two read ports and one write port; it needs no clearing pass after reset.
module box_blur_3x3_edge_normalized_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bb3_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bb3_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]        i_cfg_data
);

    // Column index, width value and a compare width that also holds the 11-bit register
    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WW > bb3_pkg::FW_W) ? WW : bb3_pkg::FW_W;
    localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);

    // ---------------------------------------------------------------- configuration
    logic [bb3_pkg::FW_W-1:0]  r_frame_width;
    logic [bb3_pkg::FH_W-1:0]  r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bb3_pkg::FW_RESET;
            r_frame_height <= bb3_pkg::FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bb3_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[bb3_pkg::FW_W-1:0];
                bb3_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate the geometry into its working range; it is read live at every pixel
    logic [XW-1:0]             w_cfg_x;
    logic [XW-1:0]             w_eff_x;
    logic [WW-1:0]             w_eff;
    logic [bb3_pkg::FH_W-1:0]  h_eff;

    always_comb begin
        w_cfg_x = XW'(r_frame_width);
        if (w_cfg_x < XW'(2)) begin
            w_eff_x = XW'(2);
        end else if (w_cfg_x > MAXW_X) begin
            w_eff_x = MAXW_X;
        end else begin
            w_eff_x = w_cfg_x;
        end
        w_eff = w_eff_x[WW-1:0];
        if (r_frame_height < bb3_pkg::FH_W'(2)) begin
            h_eff = bb3_pkg::FH_W'(2);
        end else if (r_frame_height > bb3_pkg::HEIGHT_LIMIT) begin
            h_eff = bb3_pkg::HEIGHT_LIMIT;
        end else begin
            h_eff = r_frame_height;
        end
    end

    // ---------------------------------------------------------------- stage 0: accept
    logic [CW-1:0]              r_col;
    logic [bb3_pkg::ROW_W-1:0]  r_row;
    logic [WW-1:0]              r_drain_cnt;
    logic [WW-1:0]              r_drain_w;
    logic [CW-1:0]              n_col;
    logic [bb3_pkg::ROW_W-1:0]  n_row;
    logic [WW-1:0]              n_drain_cnt;
    logic [WW-1:0]              n_drain_w;
    bb3_pkg::t_ctl              n_ctl;

    logic                       in_acc;
    logic                       drain_pend;
    logic                       drain_ok;
    logic [CW-1:0]              cur_col;
    logic [bb3_pkg::ROW_W-1:0]  cur_row;
    logic [WW-1:0]              col_inc;
    logic [bb3_pkg::FH_W-1:0]   row_inc;
    logic                       row_end;
    logic                       frame_end;
    logic                       emit1;
    logic                       emit2;
    logic [WW-1:0]              d_col_x;
    logic [WW-1:0]              d_inc;
    logic                       d_left;
    logic                       d_right;
    logic [CW-1:0]              rd_addr_a;
    logic [CW-1:0]              rd_addr_b;

    // Credit: every beat already in the pipe has a queue slot reserved
    logic [bb3_pkg::QCNT_W-1:0] q_level;
    logic [3:0]                 pending;
    logic [5:0]                 need;

    bb3_pkg::t_ctl              r_s1;
    bb3_pkg::t_ctl              r_s2;
    bb3_pkg::t_ctl              r_s3;
    bb3_pkg::t_ctl              r_s4;

    assign pending = 4'(r_s1.n_res) + 4'(r_s2.n_res) + 4'(r_s3.n_res) + 4'(r_s4.n_res);
    assign need    = 6'(q_level) + 6'(pending) + 6'd2;
    // Stall while the queue could not take two more beats behind those in flight
    assign o_in_stall = (need > 6'(bb3_pkg::QUEUE_DEPTH));
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        drain_pend = (r_drain_cnt != '0);
        drain_ok   = drain_pend && (r_drain_cnt <= r_drain_w);
        // A pixel arriving over pending drain beats restarts the frame at the origin
        cur_col    = drain_pend ? '0 : r_col;
        cur_row    = drain_pend ? '0 : r_row;
        col_inc    = WW'(cur_col) + WW'(1);
        row_inc    = bb3_pkg::FH_W'(cur_row) + bb3_pkg::FH_W'(1);
        row_end    = (col_inc >= w_eff);
        frame_end  = (row_inc >= h_eff);
        emit1      = (cur_row != '0) && (cur_col != '0);
        emit2      = emit1 && row_end;
        // Drain walks the last row left to right out of the line store
        d_col_x    = r_drain_w - r_drain_cnt;
        d_inc      = d_col_x + WW'(1);
        d_left     = (d_col_x != '0);
        d_right    = (d_inc < r_drain_w);
        rd_addr_a  = (i_in_data.action == bb3_pkg::ACT_DRAIN) ? d_col_x[CW-1:0] : cur_col;
        rd_addr_b  = d_right ? d_inc[CW-1:0] : d_col_x[CW-1:0];
    end

    always_comb begin
        n_ctl       = '0;
        n_col       = r_col;
        n_row       = r_row;
        n_drain_cnt = r_drain_cnt;
        n_drain_w   = r_drain_w;
        if (in_acc) begin
            if (i_in_data.action == bb3_pkg::ACT_DRAIN) begin
                if (drain_ok) begin
                    n_ctl.kind         = bb3_pkg::KIND_DRAIN;
                    n_ctl.n_res        = 2'd1;
                    n_ctl.rows         = bb3_pkg::ROWS_DRAIN;
                    n_ctl.cols_a       = {d_right, 1'b1, d_left};
                    n_ctl.run_last_a   = 1'b1;
                    n_ctl.frame_last_a = (r_drain_cnt == WW'(1));
                    n_drain_cnt        = r_drain_cnt - WW'(1);
                end else begin
                    // Nothing to give: drop the tick
                    n_drain_cnt = '0;
                end
            end else begin
                n_ctl.kind         = bb3_pkg::KIND_PIXEL;
                n_ctl.n_res        = 2'(emit1) + 2'(emit2);
                n_ctl.rows         = {2'b11, (cur_row >= bb3_pkg::ROW_W'(2))};
                n_ctl.cols_a       = {2'b11, (cur_col >= CW'(2))};
                n_ctl.run_last_a   = !row_end;
                n_ctl.frame_last_a = 1'b0;
                n_drain_cnt        = '0;
                if (row_end) begin
                    n_col = '0;
                    if (frame_end) begin
                        n_row       = '0;
                        n_drain_cnt = w_eff;
                        n_drain_w   = w_eff;
                    end else begin
                        n_row = row_inc[bb3_pkg::ROW_W-1:0];
                    end
                end else begin
                    n_col = col_inc[CW-1:0];
                    n_row = cur_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_drain_cnt <= '0;
            r_drain_w   <= '0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_drain_cnt <= n_drain_cnt;
            r_drain_w   <= n_drain_w;
        end
    end

    // Control pipeline: advance every clock, never held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else begin
            r_s1 <= n_ctl;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
        end
    end

    logic [bb3_pkg::PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]             r_s1_addr;

    always_ff @(posedge i_clk) begin
        r_s1_pix  <= {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};
        r_s1_addr <= rd_addr_a;
    end

    // ---------------------------------------------------------------- line store
    // Entry holds {row r-2, row r-1} for its column. Two registered read ports, one write.
    logic [bb3_pkg::ENTRY_W-1:0] r_line_store [MAX_WIDTH];
    logic [bb3_pkg::ENTRY_W-1:0] r_rd_a;
    logic [bb3_pkg::ENTRY_W-1:0] r_rd_b;
    logic [bb3_pkg::ENTRY_W-1:0] r_byp_data;
    logic                        r_byp_a;
    logic                        r_byp_b;
    logic                        wr_en;
    logic [bb3_pkg::ENTRY_W-1:0] wr_data;
    logic [bb3_pkg::ENTRY_W-1:0] data_a;
    logic [bb3_pkg::ENTRY_W-1:0] data_b;

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_line_store[rd_addr_a];
        r_rd_b <= r_line_store[rd_addr_b];
        if (wr_en) begin
            r_line_store[r_s1_addr] <= wr_data;
        end
    end

    // Forward a write that lands on the edge of the read (last pixel of a frame
    // followed at once by drain ticks on a narrow frame)
    always_ff @(posedge i_clk) begin
        r_byp_a    <= wr_en && (r_s1_addr == rd_addr_a);
        r_byp_b    <= wr_en && (r_s1_addr == rd_addr_b);
        r_byp_data <= wr_data;
    end

    assign data_a  = r_byp_a ? r_byp_data : r_rd_a;
    assign data_b  = r_byp_b ? r_byp_data : r_rd_b;
    assign wr_en   = (r_s1.kind == bb3_pkg::KIND_PIXEL);
    assign wr_data = {data_a[bb3_pkg::PIX_W-1:0], r_s1_pix};

    // ---------------------------------------------------------------- stage 1: windows
    // r_win[row][col]: row 0 = two rows up, row 2 = current row; col 0 = oldest column
    logic [2:0][2:0][bb3_pkg::PIX_W-1:0] r_win;
    logic [2:0][2:0][bb3_pkg::PIX_W-1:0] n_win;
    // Drain window: columns col-1, col, col+1 of the last two rows
    logic [2:0][bb3_pkg::ENTRY_W-1:0]    r_dwin;
    logic [bb3_pkg::ENTRY_W-1:0]         r_dprev;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = data_a[bb3_pkg::ENTRY_W-1:bb3_pkg::PIX_W];
        n_win[1][2] = data_a[bb3_pkg::PIX_W-1:0];
        n_win[2][2] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.kind == bb3_pkg::KIND_PIXEL) begin
            r_win <= n_win;
        end
        if (r_s1.kind == bb3_pkg::KIND_DRAIN) begin
            r_dwin  <= {data_b, data_a, r_dprev};
            r_dprev <= data_a;
        end
    end

    // ---------------------------------------------------------------- stages 2-3: lanes
    logic [2:0][2:0][bb3_pkg::PIX_W-1:0] src;
    logic [2:0][2:0][2:0][7:0]           lane_px;
    logic [2:0][7:0]                     lane_q_a;
    logic [2:0][7:0]                     lane_q_b;
    bb3_pkg::t_div                       div_a;
    bb3_pkg::t_div                       div_b;

    // Pick the window of the item in stage 2; the drain window has no third row
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r_s2.kind == bb3_pkg::KIND_DRAIN) begin
                    if (r == 0) begin
                        src[r][c] = r_dwin[c][bb3_pkg::ENTRY_W-1:bb3_pkg::PIX_W];
                    end else if (r == 1) begin
                        src[r][c] = r_dwin[c][bb3_pkg::PIX_W-1:0];
                    end else begin
                        src[r][c] = '0;
                    end
                end else begin
                    src[r][c] = r_win[r][c];
                end
                for (int l = 0; l < 3; l++) begin
                    lane_px[l][r][c] = src[r][c][8*l +: 8];
                end
            end
        end
        div_a = bb3_pkg::f_div_code(r_s2.rows, r_s2.cols_a);
        div_b = bb3_pkg::f_div_code(r_s2.rows, bb3_pkg::COLS_RIGHT2);
    end

    // One lane per color channel: lane 0 blue, lane 1 green, lane 2 red
    for (genvar g = 0; g < 3; g++) begin : g_lane
        bb3_lane u_lane (
            .i_clk    (i_clk),
            .i_px     (lane_px[g]),
            .i_rows   (r_s2.rows),
            .i_cols_a (r_s2.cols_a),
            .i_div_a  (div_a),
            .i_div_b  (div_b),
            .o_q_a    (lane_q_a[g]),
            .o_q_b    (lane_q_b[g])
        );
    end

    // ---------------------------------------------------------------- stage 4: merge
    bb3_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_s4),
        .i_q_a       (lane_q_a),
        .i_q_b       (lane_q_b),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_level     (q_level)
    );

    // ---------------------------------------------------------------- checks
    a_credit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (6'(q_level) + 6'(pending)) <= 6'(bb3_pkg::QUEUE_DEPTH))
        else $error("beats in flight exceed queue room");

    a_drain_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain_cnt <= r_drain_w)
        else $error("drain count beyond latched row length");

    a_drain_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.kind == bb3_pkg::KIND_DRAIN) |-> (r_s1.n_res == 2'd1))
        else $error("drain item with beat count other than one");

    a_drain_from_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_drain_cnt != '0) |->
            $past(in_acc && (i_in_data.action == bb3_pkg::ACT_PIXEL)))
        else $error("drain armed without a frame-ending pixel");

endmodule
